@@ rtl/core/lprf_pkg.sv @@
package lprf_pkg;

    localparam int LPRF_DIM_BITS       = 12;
    localparam int LPRF_CFG_BITS       = 16;
    localparam int LPRF_TOTAL_BITS     = 16;
    localparam int LPRF_COORD_BITS_DEF = 12;
    localparam int LPRF_COUNT_BITS_DEF = 16;

    localparam logic [LPRF_DIM_BITS-1:0] LPRF_FRAME_WIDTH_RST  = 12'd320;
    localparam logic [LPRF_DIM_BITS-1:0] LPRF_FRAME_HEIGHT_RST = 12'd240;
    localparam logic [LPRF_CFG_BITS-1:0] LPRF_NO_LEAF_MIN_RST  = 16'd185;
    localparam logic [LPRF_CFG_BITS-1:0] LPRF_USABLE_MIN_RST   = 16'd553;

    localparam logic [7:0] LPRF_MAX_LO   = 8'd30;
    localparam logic [7:0] LPRF_MAX_HI   = 8'd252;
    localparam logic [7:0] LPRF_SPAN_MIN = 8'd15;

    localparam int LPRF_GROW_MIN = 16;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_NO_LEAF_MIN  = 2'd2,
        CFG_USABLE_MIN   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_AIM    = 2'd1,
        CLS_USABLE = 2'd2
    } t_class;

endpackage

@@ rtl/core/lprf_leaf_chk.sv @@
module lprf_leaf_chk
    import lprf_pkg::*;
(
    input  logic [15:0] i_word,
    output logic        o_is_leaf
);

    function automatic logic [7:0] chan5(input logic [4:0] v);
        logic [2:0] k;
        k = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
          + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
        return {v, 3'b000} + 8'(k);
    endfunction

    function automatic logic [7:0] chan6(input logic [5:0] v);
        logic [1:0] k;
        k = 2'(v >= 6'd21) + 2'(v >= 6'd42);
        return {v, 2'b00} + 8'(k);
    endfunction

    logic [7:0]  r8, g8, b8, mx, mn;
    logic [15:0] r, g, b;
    logic        span_ok, greenish, yellow, dark, dry;

    always_comb begin
        r8 = chan5(i_word[15:11]);
        g8 = chan6(i_word[10:5]);
        b8 = chan5(i_word[4:0]);
        r  = 16'(r8);
        g  = 16'(g8);
        b  = 16'(b8);

        mx = r8;
        mn = r8;
        if (g8 > mx) mx = g8;
        if (b8 > mx) mx = b8;
        if (g8 < mn) mn = g8;
        if (b8 < mn) mn = b8;

        span_ok = (mx >= LPRF_MAX_LO) && (mx <= LPRF_MAX_HI) && ((mx - mn) >= LPRF_SPAN_MIN);

        // The percentage tests are rewritten as exact integer cross products.
        greenish = (g8 > 8'd38) && ({g, 1'b0} > r + b + 16'd10)
                && (16'd7 * r <= 16'd10 * g + 16'd9)
                && (16'd9 * b <= 16'd10 * g + 16'd9);
        yellow   = (r8 > 8'd45) && (g8 > 8'd45) && (b8 < 8'd150)
                && (16'd55 * r <= 16'd100 * g + 16'd99)
                && (16'd55 * g <= 16'd100 * r + 16'd99);
        dark     = (g8 > 8'd35) && (16'd95 * r < 16'd100 * g)
                && (16'd105 * b < 16'd100 * g);
        dry      = (r8 > 8'd50) && (g8 > 8'd28) && (b8 < 8'd115)
                && (16'd9 * g <= 16'd10 * r + 16'd9)
                && (16'd12 * b < 16'd10 * r);

        o_is_leaf = span_ok && (greenish || yellow || dark || dry);
    end

endmodule

@@ rtl/core/leaf_pixel_roi_finder_core.sv @@
// A frame-end pixel goes through the input, leaf and result stages to the output.
// Throughput: one pixel per cycle unless stalled, set by the leaf test and box update stages.
// A waiting result holds only a frame-end pixel in the leaf stage, and the input behind it.
// Reset is synchronous and active low; it loads the default frame size and thresholds
// and clears all leaf counts, so the first frame starts empty.
module leaf_pixel_roi_finder_core
    import lprf_pkg::*;
#(
    parameter int COORD_BITS = LPRF_COORD_BITS_DEF,
    parameter int COUNT_BITS = LPRF_COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // first_byte[7:0], second_byte[15:8], pixel_x[27:16], pixel_y[39:28]
    input  logic [39:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // leaf_total[15:0], region_x[27:16], region_y[39:28], region_size[51:40], zeros above
    output logic [55:0] o_m_axis_tdata,
    // swapped_order[0], frame_class[2:1]
    output logic [2:0]  o_m_axis_tuser,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    localparam int DW   = LPRF_DIM_BITS;
    localparam int K    = ((COORD_BITS + 3) / 2) * 2;
    localparam int M    = ((1 << K) + 2) / 3;
    localparam int MW   = COORD_BITS + 1 + K;
    localparam int SW   = (COORD_BITS + 3 > DW + 1) ? COORD_BITS + 3 : DW + 1;
    localparam int WD   = ((COORD_BITS > DW) ? COORD_BITS : DW) + 3;
    localparam int CMPW = (COUNT_BITS > LPRF_CFG_BITS) ? COUNT_BITS : LPRF_CFG_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic                       swp;
        logic [LPRF_TOTAL_BITS-1:0] total;
        t_class                     cls;
        logic                       nz;
        logic [DW-1:0]              crop;
        logic [DW-1:0]              x0;
        logic [DW-1:0]              y0;
    } t_frm;

    // configuration
    logic [DW-1:0]            r_width, r_height;
    logic [LPRF_CFG_BITS-1:0] r_no_leaf_min, r_usable_min;

    // input and leaf test stages
    logic                  r_s0_vld, r_s0_last;
    logic [7:0]            r_s0_b0, r_s0_b1;
    logic [COORD_BITS-1:0] r_s0_x, r_s0_y;
    logic                  r_s1_vld, r_s1_last;
    logic [1:0]            r_s1_leaf;
    logic [COORD_BITS-1:0] r_s1_x, r_s1_y;
    logic                  leaf_nrm, leaf_swp;

    // per byte order accumulators, index 0 normal and 1 swapped
    logic [COUNT_BITS-1:0] r_cnt [2];
    logic [COORD_BITS-1:0] r_min_x [2], r_min_y [2], r_max_x [2], r_max_y [2];
    logic [COUNT_BITS-1:0] n_cnt [2];
    logic [COORD_BITS-1:0] n_min_x [2], n_min_y [2], n_max_x [2], n_max_y [2];
    logic                  n_swp;

    // result stages
    logic                  r_v1, r_v2, r_v3, r_v4, r_v5;
    logic                  rdy1, rdy2, rdy3, rdy4, rdy5;
    logic                  s0_rdy, s1_rdy, s1_go;
    logic                  r1_swp;
    logic [COUNT_BITS-1:0] r1_cnt;
    logic [COORD_BITS-1:0] r1_min_x, r1_min_y, r1_max_x, r1_max_y;
    t_frm                  r2_frm, r3_frm, r4_frm, n_frm;
    logic [COORD_BITS:0]   r2_side0, r3_side0, n_side0, bw, bh;
    logic [COORD_BITS-1:0] r2_cx, r2_cy, r3_cx, r3_cy, r4_cx, r4_cy, n_cx, n_cy;
    logic [COORD_BITS-1:0] r3_grow, n_grow, grow_use;
    logic [MW-1:0]         grow_prod;
    logic [DW-1:0]         r4_side, n_side;
    logic [SW-1:0]         side1, side_lo;
    logic [DW-1:0]         crop;
    logic [CMPW-1:0]       cmp_cnt;
    logic signed [WD-1:0]  t_x, t_y, lo_x, lo_y, hi_x, hi_y;
    logic                  r5_swp;
    t_class                r5_cls;
    logic [LPRF_TOTAL_BITS-1:0] r5_total;
    logic [DW-1:0]         r5_rx, r5_ry, r5_rs, n_rx, n_ry, n_rs;

    lprf_leaf_chk u_leaf_nrm (
        .i_word    ({r_s0_b0, r_s0_b1}),
        .o_is_leaf (leaf_nrm)
    );

    lprf_leaf_chk u_leaf_swp (
        .i_word    ({r_s0_b1, r_s0_b0}),
        .o_is_leaf (leaf_swp)
    );

    // handshake chain
    assign rdy5   = !r_v5 || i_m_axis_tready;
    assign rdy4   = !r_v4 || rdy5;
    assign rdy3   = !r_v3 || rdy4;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign s1_go  = r_s1_vld && (!r_s1_last || rdy1);
    assign s1_rdy = !r_s1_vld || s1_go;
    assign s0_rdy = !r_s0_vld || s1_rdy;

    assign o_s_axis_tready = s0_rdy;
    assign o_m_axis_tvalid = r_v5;
    assign o_m_axis_tdata  = {4'b0000, r5_rs, r5_ry, r5_rx, r5_total};
    assign o_m_axis_tuser  = {r5_cls, r5_swp};

    // accumulator update with the pixel in the leaf stage
    always_comb begin
        for (int o = 0; o < 2; o++) begin
            n_cnt[o]   = r_cnt[o];
            n_min_x[o] = r_min_x[o];
            n_min_y[o] = r_min_y[o];
            n_max_x[o] = r_max_x[o];
            n_max_y[o] = r_max_y[o];
            if (r_s1_leaf[o]) begin
                if (r_cnt[o] == '0) begin
                    n_min_x[o] = r_s1_x;
                    n_min_y[o] = r_s1_y;
                    n_max_x[o] = r_s1_x;
                    n_max_y[o] = r_s1_y;
                end else begin
                    if (r_s1_x < r_min_x[o]) n_min_x[o] = r_s1_x;
                    if (r_s1_y < r_min_y[o]) n_min_y[o] = r_s1_y;
                    if (r_s1_x > r_max_x[o]) n_max_x[o] = r_s1_x;
                    if (r_s1_y > r_max_y[o]) n_max_y[o] = r_s1_y;
                end
                if (r_cnt[o] != CNT_MAX) n_cnt[o] = r_cnt[o] + 1'b1;
            end
        end
        n_swp = n_cnt[1] > n_cnt[0];
    end

    // box geometry, crop and class
    always_comb begin
        bw      = {1'b0, r1_max_x} - {1'b0, r1_min_x} + 1'b1;
        bh      = {1'b0, r1_max_y} - {1'b0, r1_min_y} + 1'b1;
        n_side0 = (bw > bh) ? bw : bh;
        n_cx    = COORD_BITS'(({1'b0, r1_min_x} + {1'b0, r1_max_x}) >> 1);
        n_cy    = COORD_BITS'(({1'b0, r1_min_y} + {1'b0, r1_max_y}) >> 1);
        crop    = (r_width < r_height) ? r_width : r_height;
        cmp_cnt = CMPW'(r1_cnt);

        n_frm.swp   = r1_swp;
        n_frm.total = LPRF_TOTAL_BITS'(r1_cnt);
        n_frm.nz    = r1_cnt != '0;
        n_frm.crop  = crop;
        n_frm.x0    = (r_width - crop) >> 1;
        n_frm.y0    = (r_height - crop) >> 1;
        if (cmp_cnt < CMPW'(r_no_leaf_min)) begin
            n_frm.cls = CLS_NONE;
        end else if (cmp_cnt < CMPW'(r_usable_min)) begin
            n_frm.cls = CLS_AIM;
        end else begin
            n_frm.cls = CLS_USABLE;
        end
    end

    // side divided by three through a reciprocal multiply
    assign grow_prod = MW'(r2_side0) * MW'(M);
    assign n_grow    = COORD_BITS'(grow_prod >> K);

    always_comb begin
        grow_use = (r3_grow > COORD_BITS'(LPRF_GROW_MIN)) ? r3_grow
                                                          : COORD_BITS'(LPRF_GROW_MIN);
        side1    = SW'(r3_side0) + SW'(grow_use);
        side_lo  = SW'(r3_frm.crop >> 2);
        if (side1 < side_lo) side1 = side_lo;
        if (side1 > SW'(r3_frm.crop)) side1 = SW'(r3_frm.crop);
        n_side   = DW'(side1);
    end

    // corner placement inside the crop
    always_comb begin
        t_x  = $signed(WD'(r4_cx)) - $signed(WD'(r4_side >> 1));
        t_y  = $signed(WD'(r4_cy)) - $signed(WD'(r4_side >> 1));
        lo_x = $signed(WD'(r4_frm.x0));
        lo_y = $signed(WD'(r4_frm.y0));
        hi_x = lo_x + $signed(WD'(r4_frm.crop)) - $signed(WD'(r4_side));
        hi_y = lo_y + $signed(WD'(r4_frm.crop)) - $signed(WD'(r4_side));
        if (t_x < lo_x) t_x = lo_x;
        if (t_x > hi_x) t_x = hi_x;
        if (t_y < lo_y) t_y = lo_y;
        if (t_y > hi_y) t_y = hi_y;
        if (r4_frm.nz) begin
            n_rx = t_x[DW-1:0];
            n_ry = t_y[DW-1:0];
            n_rs = r4_side;
        end else begin
            n_rx = r4_frm.x0;
            n_ry = r4_frm.y0;
            n_rs = r4_frm.crop;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= LPRF_FRAME_WIDTH_RST;
            r_height      <= LPRF_FRAME_HEIGHT_RST;
            r_no_leaf_min <= LPRF_NO_LEAF_MIN_RST;
            r_usable_min  <= LPRF_USABLE_MIN_RST;
            r_s0_vld      <= 1'b0;
            r_s1_vld      <= 1'b0;
            r_cnt[0]      <= '0;
            r_cnt[1]      <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_v4          <= 1'b0;
            r_v5          <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FRAME_WIDTH:  r_width       <= i_cfg_wdata[DW-1:0];
                    CFG_FRAME_HEIGHT: r_height      <= i_cfg_wdata[DW-1:0];
                    CFG_NO_LEAF_MIN:  r_no_leaf_min <= i_cfg_wdata;
                    CFG_USABLE_MIN:   r_usable_min  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s0_rdy) r_s0_vld <= i_s_axis_tvalid;
            if (s1_rdy) r_s1_vld <= r_s0_vld;
            if (s1_go) begin
                if (r_s1_last) begin
                    r_cnt[0] <= '0;
                    r_cnt[1] <= '0;
                end else begin
                    r_cnt[0] <= n_cnt[0];
                    r_cnt[1] <= n_cnt[1];
                end
            end
            if (rdy1) r_v1 <= r_s1_vld && r_s1_last;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s0_rdy) begin
            r_s0_b0   <= i_s_axis_tdata[7:0];
            r_s0_b1   <= i_s_axis_tdata[15:8];
            r_s0_x    <= COORD_BITS'(i_s_axis_tdata[27:16]);
            r_s0_y    <= COORD_BITS'(i_s_axis_tdata[39:28]);
            r_s0_last <= i_s_axis_tlast;
        end
        if (s1_rdy) begin
            r_s1_leaf <= {leaf_swp, leaf_nrm};
            r_s1_x    <= r_s0_x;
            r_s1_y    <= r_s0_y;
            r_s1_last <= r_s0_last;
        end
        if (s1_go) begin
            for (int o = 0; o < 2; o++) begin
                r_min_x[o] <= n_min_x[o];
                r_min_y[o] <= n_min_y[o];
                r_max_x[o] <= n_max_x[o];
                r_max_y[o] <= n_max_y[o];
            end
        end
        if (rdy1) begin
            r1_swp   <= n_swp;
            r1_cnt   <= n_swp ? n_cnt[1] : n_cnt[0];
            r1_min_x <= n_swp ? n_min_x[1] : n_min_x[0];
            r1_min_y <= n_swp ? n_min_y[1] : n_min_y[0];
            r1_max_x <= n_swp ? n_max_x[1] : n_max_x[0];
            r1_max_y <= n_swp ? n_max_y[1] : n_max_y[0];
        end
        if (rdy2) begin
            r2_frm   <= n_frm;
            r2_side0 <= n_side0;
            r2_cx    <= n_cx;
            r2_cy    <= n_cy;
        end
        if (rdy3) begin
            r3_frm   <= r2_frm;
            r3_side0 <= r2_side0;
            r3_grow  <= n_grow;
            r3_cx    <= r2_cx;
            r3_cy    <= r2_cy;
        end
        if (rdy4) begin
            r4_frm  <= r3_frm;
            r4_side <= n_side;
            r4_cx   <= r3_cx;
            r4_cy   <= r3_cy;
        end
        if (rdy5) begin
            r5_swp   <= r4_frm.swp;
            r5_total <= r4_frm.total;
            r5_cls   <= r4_frm.cls;
            r5_rx    <= n_rx;
            r5_ry    <= n_ry;
            r5_rs    <= n_rs;
        end
    end

    // A frame end that cannot enter the result stages must leave the counts untouched.
    a_stall_holds_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_last && !rdy1) |=> ($stable(r_cnt[0]) && $stable(r_cnt[1])))
        else $error("counts changed while a frame end was stalled");

    // Once a frame end is taken, both byte orders start the next frame empty.
    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_last) |=> (r_cnt[0] == '0 && r_cnt[1] == '0))
        else $error("counts not cleared after frame end");

    // The first register must not drop a pixel while the leaf stage is blocked.
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_vld && !s1_rdy) |=> r_s0_vld)
        else $error("input register lost a pixel");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r5_cls == CLS_NONE || r5_cls == CLS_AIM || r5_cls == CLS_USABLE))
        else $error("reserved frame class on output");

endmodule
